[hdl/positional_list_engine_defines.svh]
// Shared assertion macros for the positional list engine.
`ifndef POSITIONAL_LIST_ENGINE_DEFINES_SVH
`define POSITIONAL_LIST_ENGINE_DEFINES_SVH

// Same-cycle implication.
`define PLE_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("same-cycle check failed");

// Next-cycle implication.
`define PLE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

[hdl/ple_pkg.sv]
package ple_pkg;

	localparam int DATA_W  = 32;
	localparam int POS_W   = 8;
	localparam int KIND_W  = 2;
	localparam int STAT_W  = 2;
	localparam int TOTAL_W = 7;

	typedef enum logic [KIND_W-1:0] {
		KIND_INSERT = 2'd0,
		KIND_REMOVE = 2'd1,
		KIND_READ   = 2'd2,
		KIND_FIND   = 2'd3
	} kind_t;

	typedef enum logic [STAT_W-1:0] {
		STAT_OK       = 2'd0,
		STAT_BAD      = 2'd1,
		STAT_NOTFOUND = 2'd2
	} status_t;

	// broadcast to every cell
	typedef struct packed {
		logic              ins;
		logic              rem;
		logic [POS_W-1:0]  idx;
		logic [POS_W-1:0]  count;
		logic [DATA_W-1:0] value;
	} ple_ctrl_t;

endpackage

[hdl/ple_cell.sv]
module ple_cell #(
	parameter int IDX = 0
) (
	input  logic                       clk,
	input  ple_pkg::ple_ctrl_t         ctrl,
	input  logic [ple_pkg::DATA_W-1:0] left,
	input  logic [ple_pkg::DATA_W-1:0] right,
	output logic [ple_pkg::DATA_W-1:0] data,
	output logic [ple_pkg::DATA_W-1:0] rd,
	output logic                       hit
);
	import ple_pkg::*;

	localparam logic [POS_W-1:0] ME = POS_W'(IDX);

	logic [DATA_W-1:0] data_q;
	logic              at_or_above;

	assign at_or_above = (ME >= ctrl.idx);

	always_ff @(posedge clk) begin
		if (ctrl.ins && at_or_above) begin
			data_q <= (ME == ctrl.idx) ? ctrl.value : left;
		end else if (ctrl.rem && at_or_above) begin
			data_q <= right;
		end
	end

	assign data = data_q;
	assign rd   = (ME == ctrl.idx) ? data_q : '0;
	assign hit  = (ME < ctrl.count) && (data_q == ctrl.value);

endmodule

[hdl/ple_first_hit.sv]
module ple_first_hit #(
	parameter int N = 64
) (
	input  logic [N-1:0]              hits,
	output logic                      any,
	output logic [ple_pkg::POS_W-1:0] pos
);
	import ple_pkg::*;

	logic [N-1:0] lowest;

	// isolate lowest set bit
	assign lowest = hits & (~hits + N'(1));
	assign any    = |hits;

	always_comb begin
		pos = '0;
		for (int i = 0; i < N; i++) begin
			if (lowest[i]) begin
				pos = pos | POS_W'(i + 1);
			end
		end
	end

endmodule

[hdl/positional_list_engine.sv]
// channel | direction | handshake            | word
// req     | in        | req_valid/req_stall  | kind, position, value
// rsp     | out       | rsp_valid/rsp_stall  | status, result_value, found_position,
//         |           |                      | entry_total, is_empty
//
// One word per cycle sustained while rsp_stall is low; results pass the stage-one and output registers.
// Each entry lives in its own cell; insert/remove shift the cells at and above the position at once.
// Find registers per-cell match bits, then a lowest-bit encoder picks the position.
// arst_n clears the count and the valid flags; list contents need no reset.
// rsp_stall holds the output register and then backs up into req_stall.
module positional_list_engine #(
	parameter int CAPACITY = 64
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               req_valid,
	output logic                               req_stall,
	input  logic [ple_pkg::KIND_W-1:0]         kind,
	input  logic [ple_pkg::POS_W-1:0]          position,
	input  logic signed [ple_pkg::DATA_W-1:0]  value,
	output logic                               rsp_valid,
	input  logic                               rsp_stall,
	output logic [ple_pkg::STAT_W-1:0]         status,
	output logic signed [ple_pkg::DATA_W-1:0]  result_value,
	output logic [ple_pkg::POS_W-1:0]          found_position,
	output logic [ple_pkg::TOTAL_W-1:0]        entry_total,
	output logic                               is_empty
);
	import ple_pkg::*;

	localparam int CW = $clog2(CAPACITY + 1);

	logic [CW-1:0]      count_q, count_d;
	logic               accept, advance;
	kind_t              op;
	logic [POS_W:0]     pos_x, cnt_x;
	logic               cnt_zero, pos_zero, ins_ok, acc_ok;
	ple_ctrl_t          ctrl;
	status_t            stat_d;
	logic [DATA_W-1:0]  rd_or;

	logic [DATA_W-1:0]  cell_data [CAPACITY];
	logic [DATA_W-1:0]  cell_rd [CAPACITY];
	logic [CAPACITY-1:0] cell_hit;

	logic                s1_valid_q;
	kind_t               kind_s1;
	status_t             status_s1;
	logic [DATA_W-1:0]   rdata_s1;
	logic [CAPACITY-1:0] match_s1;
	logic [TOTAL_W-1:0]  total_s1;
	logic                empty_s1;

	logic                hit_any;
	logic [POS_W-1:0]    hit_pos;

	logic                rsp_valid_q;
	logic [STAT_W-1:0]   status_q;
	logic [DATA_W-1:0]   result_q;
	logic [POS_W-1:0]    found_q;
	logic [TOTAL_W-1:0]  total_q;
	logic                empty_q;

	assign op       = kind_t'(kind);
	assign pos_x    = {1'b0, position};
	assign cnt_x    = (POS_W + 1)'(count_q);
	assign cnt_zero = (count_q == '0);
	assign pos_zero = (position == '0);
	assign ins_ok   = cnt_zero || (!pos_zero && (pos_x <= cnt_x + (POS_W + 1)'(1))
		&& (cnt_x < (POS_W + 1)'(CAPACITY)));
	assign acc_ok   = !cnt_zero && !pos_zero && (pos_x <= cnt_x);

	assign advance   = !rsp_valid_q || !rsp_stall;
	assign req_stall = s1_valid_q && !advance;
	assign accept    = req_valid && !req_stall;

	always_comb begin
		ctrl.ins   = accept && (op == KIND_INSERT) && ins_ok;
		ctrl.rem   = accept && (op == KIND_REMOVE) && acc_ok;
		ctrl.idx   = cnt_zero ? '0 : position - POS_W'(1);
		ctrl.count = POS_W'(count_q);
		ctrl.value = value;
	end

	always_comb begin
		priority if (ctrl.ins) begin
			count_d = count_q + CW'(1);
		end else if (ctrl.rem) begin
			count_d = count_q - CW'(1);
		end else begin
			count_d = count_q;
		end
	end

	for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
		logic [DATA_W-1:0] left_w, right_w;
		if (g == 0) begin : g_first
			assign left_w = '0;
		end else begin : g_mid
			assign left_w = cell_data[g-1];
		end
		if (g == CAPACITY - 1) begin : g_last
			assign right_w = '0;
		end else begin : g_inner
			assign right_w = cell_data[g+1];
		end
		ple_cell #(.IDX(g)) u_cell (
			.clk   (clk),
			.ctrl  (ctrl),
			.left  (left_w),
			.right (right_w),
			.data  (cell_data[g]),
			.rd    (cell_rd[g]),
			.hit   (cell_hit[g])
		);
	end

	always_comb begin
		rd_or = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			rd_or = rd_or | cell_rd[i];
		end
	end

	always_comb begin
		unique case (op)
			KIND_INSERT: stat_d = ins_ok ? STAT_OK : STAT_BAD;
			KIND_REMOVE,
			KIND_READ:   stat_d = acc_ok ? STAT_OK : STAT_BAD;
			KIND_FIND:   stat_d = STAT_OK;
			default:     stat_d = STAT_BAD;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			s1_valid_q <= 1'b0;
		end else begin
			count_q <= count_d;
			if (accept) begin
				s1_valid_q <= 1'b1;
			end else if (advance) begin
				s1_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_s1   <= op;
			status_s1 <= stat_d;
			rdata_s1  <= ((op == KIND_REMOVE || op == KIND_READ) && acc_ok) ? rd_or : '0;
			match_s1  <= cell_hit;
			total_s1  <= TOTAL_W'(count_d);
			empty_s1  <= (count_d == '0);
		end
	end

	ple_first_hit #(.N(CAPACITY)) u_first_hit (
		.hits (match_s1),
		.any  (hit_any),
		.pos  (hit_pos)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (advance) begin
			rsp_valid_q <= s1_valid_q;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && s1_valid_q) begin
			if (kind_s1 == KIND_FIND) begin
				status_q <= hit_any ? STAT_OK : STAT_NOTFOUND;
				found_q  <= hit_any ? hit_pos : '0;
			end else begin
				status_q <= status_s1;
				found_q  <= '0;
			end
			result_q <= rdata_s1;
			total_q  <= total_s1;
			empty_q  <= empty_s1;
		end
	end

	assign rsp_valid      = rsp_valid_q;
	assign status         = status_q;
	assign result_value   = result_q;
	assign found_position = found_q;
	assign entry_total    = total_q;
	assign is_empty       = empty_q;

endmodule

[hdl/ple_checker.sv]
`include "positional_list_engine_defines.svh"

module ple_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              rsp_valid,
	input logic                              rsp_stall,
	input logic [ple_pkg::STAT_W-1:0]        status,
	input logic signed [ple_pkg::DATA_W-1:0] result_value,
	input logic [ple_pkg::POS_W-1:0]         found_position,
	input logic [ple_pkg::TOTAL_W-1:0]       entry_total,
	input logic                              is_empty
);
	import ple_pkg::*;

	`PLE_ASSERT_SAME(a_empty_flag, clk, arst_n, rsp_valid, is_empty == (entry_total == '0))
	`PLE_ASSERT_SAME(a_fail_zero, clk, arst_n, rsp_valid && status != STAT_OK, result_value == '0 && found_position == '0)
	`PLE_ASSERT_SAME(a_find_only, clk, arst_n, rsp_valid && found_position != '0, status == STAT_OK && result_value == '0)
	`PLE_ASSERT_NEXT(a_rsp_hold, clk, arst_n, rsp_valid && rsp_stall, rsp_valid && $stable(status) && $stable(result_value))

endmodule

bind positional_list_engine ple_checker u_ple_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.rsp_valid      (rsp_valid),
	.rsp_stall      (rsp_stall),
	.status         (status),
	.result_value   (result_value),
	.found_position (found_position),
	.entry_total    (entry_total),
	.is_empty       (is_empty)
);
